>>> src/assert_macros.svh
// Assertion macros shared by the terminal engine modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ATTE_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("terminal engine assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ATTE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("terminal engine assertion failed");

`endif

>>> src/atte_pkg.sv
// Types, constants and colour functions of the text terminal engine.
package atte_pkg;

  localparam int TEXT_ROWS_DEF   = 30;
  localparam int TEXT_COLS_DEF   = 80;
  localparam int MAX_CSI_DEF     = 8;
  localparam int QUEUE_DEPTH_DEF = 2;

  // command fields sized for the largest grid
  localparam int ROW_CMD_W = 6;
  localparam int COL_CMD_W = 7;
  // result fields
  localparam int ROW_OUT_W = 5;
  localparam int COL_OUT_W = 7;
  localparam int RGB_W     = 24;
  localparam int PARAM_W   = 16;

  localparam logic [PARAM_W-1:0] PARAM_SAT = 16'hFFFF;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SGR   = 8'h6D;
  localparam logic [7:0] CH_ED    = 8'h4A;
  localparam logic [7:0] CH_CUP   = 8'h48;
  localparam logic [7:0] CH_HVP   = 8'h66;

  localparam logic [PARAM_W-1:0] SGR_RESET     = 16'd0;
  localparam logic [PARAM_W-1:0] SGR_BOLD      = 16'd1;
  localparam logic [PARAM_W-1:0] SGR_NORMAL    = 16'd22;
  localparam logic [PARAM_W-1:0] SGR_FG_LO     = 16'd30;
  localparam logic [PARAM_W-1:0] SGR_FG_HI     = 16'd37;
  localparam logic [PARAM_W-1:0] SGR_FG_DEF    = 16'd39;
  localparam logic [PARAM_W-1:0] SGR_BG_LO     = 16'd40;
  localparam logic [PARAM_W-1:0] SGR_BG_HI     = 16'd47;
  localparam logic [PARAM_W-1:0] SGR_BG_DEF    = 16'd49;
  localparam logic [PARAM_W-1:0] SGR_BRIGHT_LO = 16'd90;
  localparam logic [PARAM_W-1:0] SGR_BRIGHT_HI = 16'd97;
  localparam logic [PARAM_W-1:0] ED_ALL        = 16'd2;

  localparam logic [3:0] DEFAULT_IDX = 4'd8;

  typedef logic [RGB_W-1:0] rgb_t;

  localparam rgb_t FG_DEFAULT      = 24'hAAAAAA;
  localparam rgb_t FG_DEFAULT_BOLD = 24'hFFFFFF;
  localparam rgb_t BG_DEFAULT      = 24'h000000;

  localparam rgb_t PAL_NORM [0:7] = '{
    24'h000000, 24'hAA0000, 24'h00AA00, 24'hAA5500,
    24'h0000AA, 24'hAA00AA, 24'h00AAAA, 24'hAAAAAA
  };
  localparam rgb_t PAL_BRIGHT [0:7] = '{
    24'h555555, 24'hFF5555, 24'h55FF55, 24'hFFFF55,
    24'h5555FF, 24'hFF55FF, 24'h55FFFF, 24'hFFFFFF
  };

  typedef enum logic [1:0] {
    ACT_DRAW   = 2'd0,
    ACT_SCROLL = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_REPORT = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ESC_TEXT,
    ESC_SEEN,
    ESC_CSI
  } esc_state_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_PRINT,
    CMD_TAB,
    CMD_LF,
    CMD_CR,
    CMD_BS,
    CMD_CUP,
    CMD_CLEAR
  } cmd_kind_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SGR,
    F_REPORT
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DRAW,
    B_SCROLL,
    B_CLEAR,
    B_REPORT
  } back_state_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [7:0]           glyph;
    logic [ROW_CMD_W-1:0] row;
    logic [COL_CMD_W-1:0] column;
    rgb_t                 fore_rgb;
    rgb_t                 back_rgb;
  } cmd_t;

  function automatic rgb_t fore_colour(input logic [3:0] idx, input logic bold);
    rgb_t c;
    if (idx[3]) begin
      c = bold ? FG_DEFAULT_BOLD : FG_DEFAULT;
    end else begin
      c = bold ? PAL_BRIGHT[idx[2:0]] : PAL_NORM[idx[2:0]];
    end
    return c;
  endfunction

  function automatic rgb_t back_colour(input logic [3:0] idx);
    rgb_t c;
    c = idx[3] ? BG_DEFAULT : PAL_NORM[idx[2:0]];
    return c;
  endfunction

endpackage

>>> src/atte_if.sv
// Handshake channels of the terminal engine: byte input, results, configuration.
interface atte_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface atte_result_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     action;
  logic [atte_pkg::ROW_OUT_W-1:0] row;
  logic [atte_pkg::COL_OUT_W-1:0] column;
  logic [7:0]                     glyph;
  logic [atte_pkg::RGB_W-1:0]     fore_rgb;
  logic [atte_pkg::RGB_W-1:0]     back_rgb;
  logic                           last;

  modport source (output valid, output action, output row, output column, output glyph,
                  output fore_rgb, output back_rgb, output last, input ready);
  modport sink   (input valid, input action, input row, input column, input glyph,
                  input fore_rgb, input back_rgb, input last, output ready);
endinterface

interface atte_cfg_if;
  logic valid;
  logic ready;
  logic enabled;

  modport source (output valid, output enabled, input ready);
  modport sink   (input valid, input enabled, output ready);
endinterface

>>> src/atte_fifo.sv
// Short command queue between the byte parser and the result sequencer.
`include "assert_macros.svh"

module atte_fifo #(
  parameter int DEPTH = atte_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  atte_pkg::cmd_t  data_in,
  input  logic            pop,
  output atte_pkg::cmd_t  data_out,
  output logic            full,
  output logic            empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  atte_pkg::cmd_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  assign full     = (fill_r == CNT_W'(DEPTH));
  assign empty    = (fill_r == '0);
  assign data_out = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    priority if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end else begin
      fill_nxt = fill_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= data_in;
    end
  end

  `ATTE_ASSERT_IMPL(fifo_no_overrun, push || pop, !(push && full) && !(pop && empty))
  `ATTE_ASSERT_NEXT(fifo_push_fills, push && !pop, !empty)

endmodule

>>> src/atte_front.sv
// Byte front end: ESC/CSI parser, SGR colour state, command classification.
`include "assert_macros.svh"

module atte_front #(
  parameter int TEXT_ROWS      = atte_pkg::TEXT_ROWS_DEF,
  parameter int TEXT_COLS      = atte_pkg::TEXT_COLS_DEF,
  parameter int MAX_CSI_VALUES = atte_pkg::MAX_CSI_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  atte_byte_if.sink      in_bus,
  atte_cfg_if.sink       cfg_bus,
  input  logic           q_full,
  output logic           q_push,
  output atte_pkg::cmd_t q_data
);

  localparam int CNT_W = $clog2(MAX_CSI_VALUES + 1);
  localparam int IDX_W = $clog2(MAX_CSI_VALUES);
  localparam int PW    = atte_pkg::PARAM_W;

  logic                    enabled_r;
  atte_pkg::front_state_t  fstate_r, fstate_nxt;
  atte_pkg::esc_state_t    esc_r, esc_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [PW-1:0]           acc_r, acc_nxt;
  logic [PW-1:0]           vals_r [MAX_CSI_VALUES];
  logic [IDX_W-1:0]        walk_r, walk_nxt;
  logic [3:0]              fidx_r, fidx_nxt;
  logic [3:0]              bidx_r, bidx_nxt;
  logic                    bold_r, bold_nxt;

  logic                    accept;
  logic                    take;
  logic                    is_digit;
  logic                    sgr_go;
  logic                    walk_last;
  logic                    vals_we;
  logic [IDX_W-1:0]        cur_idx;
  logic [PW-1:0]           walk_param;
  logic [PW-1:0]           p0, p1;
  logic [19:0]             acc_ext;
  logic [PW-1:0]           acc_sat;
  logic [PW-1:0]           cup_row, cup_col;
  atte_pkg::cmd_t          cmd;

  assign cfg_bus.ready = 1'b1;
  assign in_bus.ready  = (fstate_r == atte_pkg::F_IDLE) && !q_full;
  assign accept        = in_bus.valid && in_bus.ready;
  assign take          = accept && enabled_r;

  assign is_digit = (in_bus.byte_in >= atte_pkg::CH_ZERO) && (in_bus.byte_in <= atte_pkg::CH_NINE);
  assign sgr_go   = take && (esc_r == atte_pkg::ESC_CSI) && (in_bus.byte_in == atte_pkg::CH_SGR);

  // the open parameter lives in acc_r; closed ones in vals_r
  assign cur_idx    = IDX_W'(count_r - 1'b1);
  assign walk_last  = (CNT_W'(walk_r) == count_r - 1'b1);
  assign walk_param = walk_last ? acc_r : vals_r[walk_r];
  assign p0         = (count_r <= CNT_W'(1)) ? acc_r : vals_r[0];
  assign p1         = (count_r == CNT_W'(2)) ? acc_r : vals_r[1];

  assign acc_ext = (20'(acc_r) << 3) + (20'(acc_r) << 1)
                 + 20'(in_bus.byte_in - atte_pkg::CH_ZERO);
  assign acc_sat = (acc_ext > 20'(atte_pkg::PARAM_SAT)) ? atte_pkg::PARAM_SAT : acc_ext[PW-1:0];

  // cursor position, 1-based and clamped to the grid
  always_comb begin
    cup_row = (count_r != '0 && p0 != '0) ? p0 - 1'b1 : '0;
    cup_col = (count_r >= CNT_W'(2) && p1 != '0) ? p1 - 1'b1 : '0;
    if (cup_row >= PW'(TEXT_ROWS)) begin
      cup_row = PW'(TEXT_ROWS - 1);
    end
    if (cup_col >= PW'(TEXT_COLS)) begin
      cup_col = PW'(TEXT_COLS - 1);
    end
  end

  // next state
  always_comb begin
    fstate_nxt = fstate_r;
    unique case (fstate_r)
      atte_pkg::F_IDLE: begin
        if (sgr_go) begin
          fstate_nxt = (count_r == '0) ? atte_pkg::F_REPORT : atte_pkg::F_SGR;
        end
      end
      atte_pkg::F_SGR: begin
        if (walk_last) begin
          fstate_nxt = atte_pkg::F_REPORT;
        end
      end
      atte_pkg::F_REPORT: begin
        if (!q_full) begin
          fstate_nxt = atte_pkg::F_IDLE;
        end
      end
      default: fstate_nxt = atte_pkg::F_IDLE;
    endcase
  end

  // parser datapath and command output
  always_comb begin
    esc_nxt    = esc_r;
    count_nxt  = count_r;
    acc_nxt    = acc_r;
    walk_nxt   = walk_r;
    fidx_nxt   = fidx_r;
    bidx_nxt   = bidx_r;
    bold_nxt   = bold_r;
    vals_we    = 1'b0;
    q_push     = 1'b0;
    cmd        = '0;
    cmd.kind   = atte_pkg::CMD_NOP;

    unique case (fstate_r)
      atte_pkg::F_IDLE: begin
        if (take) begin
          q_push = 1'b1;
          if (esc_r != atte_pkg::ESC_TEXT || in_bus.byte_in == atte_pkg::CH_ESC) begin
            unique case (esc_r)
              atte_pkg::ESC_TEXT: esc_nxt = atte_pkg::ESC_SEEN;
              atte_pkg::ESC_SEEN: begin
                if (in_bus.byte_in == atte_pkg::CH_LBRK) begin
                  esc_nxt   = atte_pkg::ESC_CSI;
                  count_nxt = '0;
                  acc_nxt   = '0;
                end else begin
                  esc_nxt = atte_pkg::ESC_TEXT;
                end
              end
              atte_pkg::ESC_CSI: begin
                priority if (is_digit) begin
                  if (count_r == '0) begin
                    count_nxt = CNT_W'(1);
                  end
                  acc_nxt = acc_sat;
                end else if (in_bus.byte_in == atte_pkg::CH_SEMI) begin
                  if (count_r < CNT_W'(MAX_CSI_VALUES)) begin
                    vals_we   = (count_r != '0);
                    acc_nxt   = '0;
                    count_nxt = count_r + 1'b1;
                  end
                end else begin
                  esc_nxt = atte_pkg::ESC_TEXT;
                  priority if (in_bus.byte_in == atte_pkg::CH_SGR) begin
                    q_push   = 1'b0;
                    walk_nxt = '0;
                    if (count_r == '0) begin
                      fidx_nxt = atte_pkg::DEFAULT_IDX;
                      bidx_nxt = atte_pkg::DEFAULT_IDX;
                      bold_nxt = 1'b0;
                    end
                  end else if (in_bus.byte_in == atte_pkg::CH_ED) begin
                    if (count_r == '0 || p0 == atte_pkg::ED_ALL) begin
                      cmd.kind = atte_pkg::CMD_CLEAR;
                    end
                  end else if (in_bus.byte_in == atte_pkg::CH_CUP ||
                               in_bus.byte_in == atte_pkg::CH_HVP) begin
                    cmd.kind   = atte_pkg::CMD_CUP;
                    cmd.row    = atte_pkg::ROW_CMD_W'(cup_row);
                    cmd.column = atte_pkg::COL_CMD_W'(cup_col);
                  end else begin
                    cmd.kind = atte_pkg::CMD_NOP;
                  end
                end
              end
              default: esc_nxt = atte_pkg::ESC_TEXT;
            endcase
          end else begin
            priority if (in_bus.byte_in == atte_pkg::CH_LF) begin
              cmd.kind = atte_pkg::CMD_LF;
            end else if (in_bus.byte_in == atte_pkg::CH_CR) begin
              cmd.kind = atte_pkg::CMD_CR;
            end else if (in_bus.byte_in == atte_pkg::CH_TAB) begin
              cmd.kind  = atte_pkg::CMD_TAB;
              cmd.glyph = atte_pkg::CH_SPACE;
            end else if (in_bus.byte_in == atte_pkg::CH_BS) begin
              cmd.kind = atte_pkg::CMD_BS;
            end else if (in_bus.byte_in >= atte_pkg::CH_SPACE) begin
              cmd.kind  = atte_pkg::CMD_PRINT;
              cmd.glyph = in_bus.byte_in;
            end else begin
              cmd.kind = atte_pkg::CMD_NOP;
            end
          end
        end
      end
      atte_pkg::F_SGR: begin
        walk_nxt = walk_r + 1'b1;
        priority if (walk_param == atte_pkg::SGR_RESET) begin
          fidx_nxt = atte_pkg::DEFAULT_IDX;
          bidx_nxt = atte_pkg::DEFAULT_IDX;
          bold_nxt = 1'b0;
        end else if (walk_param == atte_pkg::SGR_BOLD) begin
          bold_nxt = 1'b1;
        end else if (walk_param == atte_pkg::SGR_NORMAL) begin
          bold_nxt = 1'b0;
        end else if (walk_param >= atte_pkg::SGR_FG_LO && walk_param <= atte_pkg::SGR_FG_HI) begin
          fidx_nxt = 4'(walk_param - atte_pkg::SGR_FG_LO);
        end else if (walk_param == atte_pkg::SGR_FG_DEF) begin
          fidx_nxt = atte_pkg::DEFAULT_IDX;
        end else if (walk_param >= atte_pkg::SGR_BG_LO && walk_param <= atte_pkg::SGR_BG_HI) begin
          bidx_nxt = 4'(walk_param - atte_pkg::SGR_BG_LO);
        end else if (walk_param == atte_pkg::SGR_BG_DEF) begin
          bidx_nxt = atte_pkg::DEFAULT_IDX;
        end else if (walk_param >= atte_pkg::SGR_BRIGHT_LO &&
                     walk_param <= atte_pkg::SGR_BRIGHT_HI) begin
          fidx_nxt = 4'(walk_param - atte_pkg::SGR_BRIGHT_LO);
          bold_nxt = 1'b1;
        end else begin
          bold_nxt = bold_r;
        end
      end
      atte_pkg::F_REPORT: begin
        q_push = !q_full;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase

    // colours as they stand after this beat
    cmd.fore_rgb = atte_pkg::fore_colour(fidx_nxt, bold_nxt);
    cmd.back_rgb = atte_pkg::back_colour(bidx_nxt);
  end

  assign q_data = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b1;
      fstate_r  <= atte_pkg::F_IDLE;
      esc_r     <= atte_pkg::ESC_TEXT;
      count_r   <= '0;
      fidx_r    <= atte_pkg::DEFAULT_IDX;
      bidx_r    <= atte_pkg::DEFAULT_IDX;
      bold_r    <= 1'b0;
    end else begin
      if (cfg_bus.valid) begin
        enabled_r <= cfg_bus.enabled;
      end
      fstate_r <= fstate_nxt;
      esc_r    <= esc_nxt;
      count_r  <= count_nxt;
      fidx_r   <= fidx_nxt;
      bidx_r   <= bidx_nxt;
      bold_r   <= bold_nxt;
    end
    acc_r  <= acc_nxt;
    walk_r <= walk_nxt;
    if (vals_we) begin
      vals_r[cur_idx] <= acc_r;
    end
  end

  `ATTE_ASSERT_IMPL(front_walk_has_params, fstate_r == atte_pkg::F_SGR, count_r != '0)

endmodule

>>> src/atte_back.sv
// Result sequencer: cursor state, draws, scrolls, clears and cursor reports.
`include "assert_macros.svh"

module atte_back #(
  parameter int TEXT_ROWS = atte_pkg::TEXT_ROWS_DEF,
  parameter int TEXT_COLS = atte_pkg::TEXT_COLS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  atte_pkg::cmd_t q_data,
  output logic           q_pop,
  atte_result_if.source  out_bus
);

  localparam int ROW_W = $clog2(TEXT_ROWS);
  localparam int COL_W = $clog2(TEXT_COLS);

  atte_pkg::back_state_t bstate_r, bstate_nxt;
  atte_pkg::cmd_t        cur_r, cur_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic [COL_W-1:0]      col_r, col_nxt;

  logic                            out_valid_r, out_valid_nxt;
  atte_pkg::action_t               act_r, act_nxt;
  logic [atte_pkg::ROW_OUT_W-1:0]  orow_r, orow_nxt;
  logic [atte_pkg::COL_OUT_W-1:0]  ocol_r, ocol_nxt;
  logic [7:0]                      glyph_r, glyph_nxt;
  atte_pkg::rgb_t                  fore_r, fore_nxt;
  atte_pkg::rgb_t                  back_r, back_nxt;
  logic                            last_r, last_nxt;

  logic             load;
  logic             emit;
  logic             row_last;
  logic [COL_W:0]   col_p1;
  logic             col_wrap;

  assign load     = !out_valid_r || out_bus.ready;
  assign row_last = (row_r == ROW_W'(TEXT_ROWS - 1));
  assign col_p1   = {1'b0, col_r} + 1'b1;
  assign col_wrap = (col_p1 >= (COL_W + 1)'(TEXT_COLS));

  assign out_bus.valid    = out_valid_r;
  assign out_bus.action   = act_r;
  assign out_bus.row      = orow_r;
  assign out_bus.column   = ocol_r;
  assign out_bus.glyph    = glyph_r;
  assign out_bus.fore_rgb = fore_r;
  assign out_bus.back_rgb = back_r;
  assign out_bus.last     = last_r;

  // next state
  always_comb begin
    bstate_nxt = bstate_r;
    unique case (bstate_r)
      atte_pkg::B_IDLE: begin
        if (!q_empty) begin
          unique case (q_data.kind)
            atte_pkg::CMD_PRINT, atte_pkg::CMD_TAB: bstate_nxt = atte_pkg::B_DRAW;
            atte_pkg::CMD_LF:    bstate_nxt = row_last ? atte_pkg::B_SCROLL : atte_pkg::B_REPORT;
            atte_pkg::CMD_CLEAR: bstate_nxt = atte_pkg::B_CLEAR;
            default:             bstate_nxt = atte_pkg::B_REPORT;
          endcase
        end
      end
      atte_pkg::B_DRAW: begin
        if (load) begin
          priority if (col_wrap) begin
            bstate_nxt = row_last ? atte_pkg::B_SCROLL : atte_pkg::B_REPORT;
          end else if (cur_r.kind == atte_pkg::CMD_TAB && col_p1[2:0] != 3'd0) begin
            bstate_nxt = atte_pkg::B_DRAW;
          end else begin
            bstate_nxt = atte_pkg::B_REPORT;
          end
        end
      end
      atte_pkg::B_SCROLL, atte_pkg::B_CLEAR: begin
        if (load) begin
          bstate_nxt = atte_pkg::B_REPORT;
        end
      end
      atte_pkg::B_REPORT: begin
        if (load) begin
          bstate_nxt = atte_pkg::B_IDLE;
        end
      end
      default: bstate_nxt = atte_pkg::B_IDLE;
    endcase
  end

  // cursor moves and result payload
  always_comb begin
    cur_nxt   = cur_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    act_nxt   = act_r;
    orow_nxt  = '0;
    ocol_nxt  = '0;
    glyph_nxt = '0;
    last_nxt  = 1'b0;

    unique case (bstate_r)
      atte_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cur_nxt = q_data;
          unique case (q_data.kind)
            atte_pkg::CMD_LF: begin
              col_nxt = '0;
              if (!row_last) begin
                row_nxt = row_r + 1'b1;
              end
            end
            atte_pkg::CMD_CR: col_nxt = '0;
            atte_pkg::CMD_BS: begin
              priority if (col_r != '0) begin
                col_nxt = col_r - 1'b1;
              end else if (row_r != '0) begin
                row_nxt = row_r - 1'b1;
                col_nxt = COL_W'(TEXT_COLS - 1);
              end else begin
                col_nxt = col_r;
              end
            end
            atte_pkg::CMD_CUP: begin
              row_nxt = ROW_W'(q_data.row);
              col_nxt = COL_W'(q_data.column);
            end
            default: col_nxt = col_r;
          endcase
        end
      end
      atte_pkg::B_DRAW: begin
        if (load) begin
          emit      = 1'b1;
          act_nxt   = atte_pkg::ACT_DRAW;
          orow_nxt  = atte_pkg::ROW_OUT_W'(row_r);
          ocol_nxt  = atte_pkg::COL_OUT_W'(col_r);
          glyph_nxt = cur_r.glyph;
          if (col_wrap) begin
            col_nxt = '0;
            if (!row_last) begin
              row_nxt = row_r + 1'b1;
            end
          end else begin
            col_nxt = col_p1[COL_W-1:0];
          end
        end
      end
      atte_pkg::B_SCROLL: begin
        if (load) begin
          emit    = 1'b1;
          act_nxt = atte_pkg::ACT_SCROLL;
        end
      end
      atte_pkg::B_CLEAR: begin
        if (load) begin
          emit    = 1'b1;
          act_nxt = atte_pkg::ACT_CLEAR;
          row_nxt = '0;
          col_nxt = '0;
        end
      end
      atte_pkg::B_REPORT: begin
        if (load) begin
          emit     = 1'b1;
          act_nxt  = atte_pkg::ACT_REPORT;
          orow_nxt = atte_pkg::ROW_OUT_W'(row_r);
          ocol_nxt = atte_pkg::COL_OUT_W'(col_r);
          last_nxt = 1'b1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase

    fore_nxt      = cur_r.fore_rgb;
    back_nxt      = cur_r.back_rgb;
    out_valid_nxt = load ? emit : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bstate_r    <= atte_pkg::B_IDLE;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bstate_r    <= bstate_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r <= cur_nxt;
    if (emit) begin
      act_r   <= act_nxt;
      orow_r  <= orow_nxt;
      ocol_r  <= ocol_nxt;
      glyph_r <= glyph_nxt;
      fore_r  <= fore_nxt;
      back_r  <= back_nxt;
      last_r  <= last_nxt;
    end
  end

  `ATTE_ASSERT_IMPL(back_cursor_in_grid, 1'b1,
                    row_r <= ROW_W'(TEXT_ROWS - 1) && col_r <= COL_W'(TEXT_COLS - 1))
  `ATTE_ASSERT_IMPL(back_last_is_report, out_valid_r && last_r, act_r == atte_pkg::ACT_REPORT)

endmodule

>>> src/ansi_text_terminal_engine_unit.sv
// Top level of the ANSI text terminal engine: parser, command queue, result sequencer.
//
//   channel   | direction | beat carries
//   ----------+-----------+------------------------------------------------------
//   in_bus    | in        | byte_in, one byte of the character stream
//   out_bus   | out       | action, row, column, glyph, fore_rgb, back_rgb, last
//   cfg_bus   | in        | enabled, always ready
//
// The parser accepts a byte only while idle and while the queue has room; SGR with
// parameters holds the parser while it applies them, one parameter a cycle, and then
// while it pushes the report. The sequencer takes a command off the queue and then
// emits one result per cycle while the output is not stalled. Reset (rst_n low, synchronous) empties
// the queue and the output stage; no clearing pass. Either side may stall: the queue
// decouples them.
module ansi_text_terminal_engine_unit #(
  parameter int TEXT_ROWS      = atte_pkg::TEXT_ROWS_DEF,
  parameter int TEXT_COLS      = atte_pkg::TEXT_COLS_DEF,
  parameter int MAX_CSI_VALUES = atte_pkg::MAX_CSI_DEF,
  parameter int QUEUE_DEPTH    = atte_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  atte_byte_if.sink     in_bus,
  atte_result_if.source out_bus,
  atte_cfg_if.sink      cfg_bus
);

  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  atte_pkg::cmd_t q_wdata;
  atte_pkg::cmd_t q_rdata;

  atte_front #(
    .TEXT_ROWS      (TEXT_ROWS),
    .TEXT_COLS      (TEXT_COLS),
    .MAX_CSI_VALUES (MAX_CSI_VALUES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .cfg_bus (cfg_bus),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  atte_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .data_in  (q_wdata),
    .pop      (q_pop),
    .data_out (q_rdata),
    .full     (q_full),
    .empty    (q_empty)
  );

  atte_back #(
    .TEXT_ROWS (TEXT_ROWS),
    .TEXT_COLS (TEXT_COLS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .out_bus (out_bus)
  );

endmodule

>>> tb/ansi_text_terminal_engine_unit_test.sv
// Self-checking testbench for the ANSI text terminal engine: byte stream in, cell actions out.
module ansi_text_terminal_engine_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import atte_pkg::*;

  localparam int ROWS      = TEXT_ROWS_DEF;
  localparam int COLS      = TEXT_COLS_DEF;
  localparam int CSI_MAX   = MAX_CSI_DEF;
  localparam int ITEMS     = 424;
  localparam int CALM_TAIL = 60;
  localparam int SETTLE    = 16;

  localparam logic [7:0] CH_BEL = 8'h07;

  typedef struct packed {
    action_t              action;
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] column;
    logic [7:0]           glyph;
    rgb_t                 fore_rgb;
    rgb_t                 back_rgb;
    logic                 last;
  } cell_action_t;

  // Tracks cursor, colours and escape parser; holds the cell actions still due.
  class screen_tracker;
    cell_action_t due_actions[$];
    int           errors;
    bit           enabled;
    int           cur_row;
    int           cur_col;
    esc_state_t   esc;
    int unsigned  csi_val[CSI_MAX];
    int           csi_cnt;
    logic [3:0]   fg_idx;
    logic [3:0]   bg_idx;
    bit           bold;
    rgb_t         fg_rgb;
    rgb_t         bg_rgb;

    function new();
      enabled = 1'b1;
      cur_row = 0;
      cur_col = 0;
      esc     = ESC_TEXT;
      csi_cnt = 0;
      fg_idx  = DEFAULT_IDX;
      bg_idx  = DEFAULT_IDX;
      bold    = 1'b0;
      fg_rgb  = FG_DEFAULT;
      bg_rgb  = BG_DEFAULT;
      errors  = 0;
    endfunction

    function int pending();
      return due_actions.size();
    endfunction

    function void set_enabled(bit v);
      enabled = v;
    endfunction

    task report(string msg);
      errors++;
      $display("%0t ERROR %s", $realtime, msg);
    endtask

    function void add_action(action_t act, int r, int c, logic [7:0] g, logic lst);
      cell_action_t a;
      a.action   = act;
      a.row      = r[ROW_OUT_W-1:0];
      a.column   = c[COL_OUT_W-1:0];
      a.glyph    = g;
      a.fore_rgb = fg_rgb;
      a.back_rgb = bg_rgb;
      a.last     = lst;
      due_actions.push_back(a);
    endfunction

    // returns the number of actions added (a scroll on the bottom row)
    function int line_feed();
      cur_col = 0;
      if (cur_row + 1 >= ROWS) begin
        cur_row = ROWS - 1;
        add_action(ACT_SCROLL, 0, 0, 8'h00, 1'b0);
        return 1;
      end
      cur_row++;
      return 0;
    endfunction

    function int step_right();
      cur_col++;
      if (cur_col >= COLS) return line_feed();
      return 0;
    endfunction

    function void note_byte(logic [7:0] b);
      int          n;
      int unsigned acc;
      int unsigned p;
      int          r;
      int          k;
      n = 0;
      if (!enabled) return;
      if (esc != ESC_TEXT || b == CH_ESC) begin
        if (esc == ESC_TEXT) begin
          esc = ESC_SEEN;
        end else if (esc == ESC_SEEN) begin
          if (b == CH_LBRK) begin
            esc        = ESC_CSI;
            csi_cnt    = 0;
            csi_val[0] = 0;
          end else begin
            esc = ESC_TEXT;
          end
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
          if (csi_cnt == 0) csi_cnt = 1;
          acc = csi_val[csi_cnt-1] * 10 + (b - CH_ZERO);
          csi_val[csi_cnt-1] = (acc > PARAM_SAT) ? PARAM_SAT : acc;
        end else if (b == CH_SEMI) begin
          // extra separators past the last slot are dropped
          if (csi_cnt < CSI_MAX) begin
            csi_val[csi_cnt] = 0;
            csi_cnt++;
          end
        end else begin
          if (b == CH_SGR) begin
            if (csi_cnt == 0) begin
              fg_idx = DEFAULT_IDX;
              bg_idx = DEFAULT_IDX;
              bold   = 1'b0;
            end
            for (int i = 0; i < csi_cnt; i++) begin
              p = csi_val[i];
              if (p == SGR_RESET) begin
                fg_idx = DEFAULT_IDX;
                bg_idx = DEFAULT_IDX;
                bold   = 1'b0;
              end else if (p == SGR_BOLD) begin
                bold = 1'b1;
              end else if (p == SGR_NORMAL) begin
                bold = 1'b0;
              end else if (p >= SGR_FG_LO && p <= SGR_FG_HI) begin
                fg_idx = 4'(p - SGR_FG_LO);
              end else if (p == SGR_FG_DEF) begin
                fg_idx = DEFAULT_IDX;
              end else if (p >= SGR_BG_LO && p <= SGR_BG_HI) begin
                bg_idx = 4'(p - SGR_BG_LO);
              end else if (p == SGR_BG_DEF) begin
                bg_idx = DEFAULT_IDX;
              end else if (p >= SGR_BRIGHT_LO && p <= SGR_BRIGHT_HI) begin
                fg_idx = 4'(p - SGR_BRIGHT_LO);
                bold   = 1'b1;
              end
            end
            if (fg_idx[3]) fg_rgb = bold ? FG_DEFAULT_BOLD : FG_DEFAULT;
            else           fg_rgb = bold ? PAL_BRIGHT[fg_idx[2:0]] : PAL_NORM[fg_idx[2:0]];
            bg_rgb = bg_idx[3] ? BG_DEFAULT : PAL_NORM[bg_idx[2:0]];
          end else if (b == CH_ED) begin
            if (csi_cnt == 0 || csi_val[0] == ED_ALL) begin
              add_action(ACT_CLEAR, 0, 0, 8'h00, 1'b0);
              cur_row = 0;
              cur_col = 0;
            end
          end else if (b == CH_CUP || b == CH_HVP) begin
            r = (csi_cnt >= 1 && csi_val[0] > 0) ? int'(csi_val[0]) - 1 : 0;
            k = (csi_cnt >= 2 && csi_val[1] > 0) ? int'(csi_val[1]) - 1 : 0;
            cur_row = (r >= ROWS) ? ROWS - 1 : r;
            cur_col = (k >= COLS) ? COLS - 1 : k;
          end
          esc = ESC_TEXT;
        end
      end else if (b == CH_LF) begin
        void'(line_feed());
      end else if (b == CH_CR) begin
        cur_col = 0;
      end else if (b == CH_TAB) begin
        do begin
          add_action(ACT_DRAW, cur_row, cur_col, CH_SPACE, 1'b0);
          n++;
          n += step_right();
        end while ((cur_col % 8) != 0 && n < 9);
      end else if (b == CH_BS) begin
        if (cur_col > 0) begin
          cur_col--;
        end else if (cur_row > 0) begin
          cur_row--;
          cur_col = COLS - 1;
        end
      end else if (b >= CH_SPACE) begin
        add_action(ACT_DRAW, cur_row, cur_col, b, 1'b0);
        void'(step_right());
      end
      add_action(ACT_REPORT, cur_row, cur_col, 8'h00, 1'b1);
    endfunction

    task check_result(cell_action_t got);
      cell_action_t want;
      if (due_actions.size() == 0) begin
        report($sformatf("unexpected beat action %0d row %0d col %0d",
                         got.action, got.row, got.column));
        return;
      end
      want = due_actions.pop_front();
      if (got.action !== want.action)
        report($sformatf("action got %0d want %0d", got.action, want.action));
      if (got.row !== want.row)
        report($sformatf("row got %0d want %0d", got.row, want.row));
      if (got.column !== want.column)
        report($sformatf("column got %0d want %0d", got.column, want.column));
      if (got.glyph !== want.glyph)
        report($sformatf("glyph got %02h want %02h", got.glyph, want.glyph));
      if (got.fore_rgb !== want.fore_rgb)
        report($sformatf("fore_rgb got %06h want %06h", got.fore_rgb, want.fore_rgb));
      if (got.back_rgb !== want.back_rgb)
        report($sformatf("back_rgb got %06h want %06h", got.back_rgb, want.back_rgb));
      if (got.last !== want.last)
        report($sformatf("last got %0b want %0b", got.last, want.last));
    endtask
  endclass

  logic clk;
  logic rst_n;

  atte_byte_if   in_bus ();
  atte_result_if out_bus ();
  atte_cfg_if    cfg_bus ();

  ansi_text_terminal_engine_unit #(
    .TEXT_ROWS      (ROWS),
    .TEXT_COLS      (COLS),
    .MAX_CSI_VALUES (CSI_MAX)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  screen_tracker tracker = new();

  bit         quiet   = 1'b0;
  bit         in_calm = 1'b0;
  logic [7:0] seq_bytes[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    #(5_000_000);
    $display("ansi_text_terminal_engine_unit_test NOT OK");
    $finish;
  end

  // result side: random stall bursts, calm stretches, none in the tail
  initial begin : result_sink
    int           stall_left;
    bit           out_calm;
    cell_action_t got;
    stall_left = 0;
    out_calm   = 1'b0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        got.action   = action_t'(out_bus.action);
        got.row      = out_bus.row;
        got.column   = out_bus.column;
        got.glyph    = out_bus.glyph;
        got.fore_rgb = out_bus.fore_rgb;
        got.back_rgb = out_bus.back_rgb;
        got.last     = out_bus.last;
        tracker.check_result(got);
      end
      if ($urandom_range(0, 59) == 0) out_calm = !out_calm;
      if (!rst_n) begin
        out_bus.ready <= 1'b0;
      end else if (stall_left > 0 && !quiet) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
        stall_left = 0;
        if (!quiet && !out_calm && $urandom_range(0, 5) == 0)
          stall_left = $urandom_range(1, 10);
      end
    end
  end

  task automatic put_byte(input logic [7:0] b);
    if (!quiet && !in_calm && $urandom_range(0, 4) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.byte_in <= b;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    tracker.note_byte(b);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_enabled(input bit v);
    cfg_bus.valid   <= 1'b1;
    cfg_bus.enabled <= v;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    tracker.set_enabled(v);
  endtask

  function automatic void add_number(input int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) seq_bytes.push_back(s[i]);
  endfunction

  // one random fragment of the stream: text, control, CSI, broken escape or noise
  task automatic send_fragment(inout int sent);
    int          kind;
    int          fin;
    int          nparam;
    int unsigned v;
    logic [7:0]  fin_byte;
    seq_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      seq_bytes.push_back(8'($urandom_range(32, 255)));
    end else if (kind < 45) begin
      case ($urandom_range(0, 6))
        0, 1:    seq_bytes.push_back(CH_LF);
        2:       seq_bytes.push_back(CH_CR);
        3:       seq_bytes.push_back(CH_TAB);
        4:       seq_bytes.push_back(CH_BS);
        5:       seq_bytes.push_back(CH_BEL);
        default: seq_bytes.push_back(8'($urandom_range(0, 31)));
      endcase
    end else if (kind < 85) begin
      fin    = $urandom_range(0, 19);
      nparam = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 11) : $urandom_range(0, 3);
      seq_bytes.push_back(CH_ESC);
      seq_bytes.push_back(CH_LBRK);
      for (int i = 0; i < nparam; i++) begin
        if (i > 0) seq_bytes.push_back(CH_SEMI);
        if (fin < 8) begin
          case ($urandom_range(0, 7))
            0:       v = SGR_RESET;
            1:       v = SGR_BOLD;
            2:       v = SGR_NORMAL;
            3:       v = SGR_FG_LO + $urandom_range(0, 7);
            4:       v = SGR_BG_LO + $urandom_range(0, 7);
            5:       v = SGR_BRIGHT_LO + $urandom_range(0, 7);
            6:       v = $urandom_range(0, 1) ? SGR_FG_DEF : SGR_BG_DEF;
            default: v = $urandom_range(0, 120);
          endcase
        end else if (fin < 14) begin
          v = $urandom_range(0, (i == 0) ? ROWS + 5 : COLS + 7);
        end else if (fin < 17) begin
          v = $urandom_range(0, 3);
        end else begin
          v = $urandom_range(0, 99);
        end
        // saturation needs values past 16 bits
        if ($urandom_range(0, 15) == 0) v = $urandom_range(60000, 9999999);
        if ($urandom_range(0, 9) != 0) add_number(v);
      end
      if (fin < 8)       fin_byte = CH_SGR;
      else if (fin < 12) fin_byte = CH_CUP;
      else if (fin < 14) fin_byte = CH_HVP;
      else if (fin < 17) fin_byte = CH_ED;
      else begin
        fin_byte = 8'($urandom_range(0, 255));
        while ((fin_byte >= CH_ZERO && fin_byte <= CH_NINE) || fin_byte == CH_SEMI)
          fin_byte = 8'($urandom_range(0, 255));
      end
      seq_bytes.push_back(fin_byte);
    end else if (kind < 92) begin
      seq_bytes.push_back(CH_ESC);
      seq_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      seq_bytes.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 11) == 0) in_calm = !in_calm;
    foreach (seq_bytes[i]) begin
      put_byte(seq_bytes[i]);
      sent++;
    end
  endtask

  initial begin : stimulus
    logic [7:0] opening[] = '{
      CH_BS, 8'h00, CH_BEL, 8'hFF, CH_TAB,
      CH_ESC, CH_ESC,
      CH_ESC, CH_LBRK, CH_NINE, CH_NINE, CH_SEMI, CH_NINE, CH_NINE, CH_CUP,
      8'h41, CH_LF, CH_BS, CH_TAB, CH_CR,
      CH_ESC, CH_LBRK, CH_SGR,
      CH_ESC, CH_LBRK, CH_ED
    };
    int  sent;
    bit  paused;
    rst_n           <= 1'b0;
    in_bus.valid    <= 1'b0;
    in_bus.byte_in  <= 8'h00;
    cfg_bus.valid   <= 1'b0;
    cfg_bus.enabled <= 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_enabled(1'b1);

    // directed: corners of the cursor grid, wraps, scrolls and escapes
    foreach (opening[i]) put_byte(opening[i]);
    drain();

    // disabled: bytes are swallowed with nothing coming back
    write_enabled(1'b0);
    repeat (20) put_byte(8'($urandom_range(0, 255)));
    in_bus.valid <= 1'b0;
    repeat (SETTLE) @(posedge clk);
    write_enabled(1'b1);

    sent   = 0;
    paused = 1'b0;
    while (sent < ITEMS) begin
      if (!paused && sent >= ITEMS / 2) begin
        drain();
        paused = 1'b1;
      end
      if (sent >= ITEMS - CALM_TAIL) quiet = 1'b1;
      send_fragment(sent);
    end

    in_bus.valid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("ansi_text_terminal_engine_unit_test OK");
    end else begin
      $display("ansi_text_terminal_engine_unit_test NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/atte_pkg.sv
src/atte_if.sv
src/atte_fifo.sv
src/atte_front.sv
src/atte_back.sv
src/ansi_text_terminal_engine_unit.sv
tb/ansi_text_terminal_engine_unit_test.sv
